// ===== rtl/ctd_pkg.sv =====
// Package for the chunked transfer decoder: widths, phase and parse codes,
// character constants and the character class helpers used by the core.
// No dependencies.
`default_nettype none

package ctd_pkg;

    localparam int LINE_KEEP = 31;
    localparam int LEN_W     = 6;
    localparam int MAG_W     = 63;

    localparam logic [MAG_W-1:0] SIZE_MAX = {MAG_W{1'b1}};

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    // Decoder phase
    localparam logic [1:0] PH_LINE = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;
    localparam logic [1:0] PH_PASS = 2'd3;

    // Size line parse stage
    localparam logic [2:0] ST_WS     = 3'd0;
    localparam logic [2:0] ST_SIGN   = 3'd1;
    localparam logic [2:0] ST_ZERO   = 3'd2;
    localparam logic [2:0] ST_X      = 3'd3;
    localparam logic [2:0] ST_DIGITS = 3'd4;
    localparam logic [2:0] ST_DEAD   = 3'd5;

    // Register map
    localparam logic [0:0] REG_CHUNKED_ENABLE = 1'b0;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       is_end;
    } t_result;

    // Returns {is_hex, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        case (c) inside
            [8'h30:8'h39]: r = {1'b1, c[3:0]};
            [8'h41:8'h46],
            [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
            default:       r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= CH_CR);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ctd_if.sv =====
// Valid/ready channel interfaces for the chunked transfer decoder:
// raw body bytes in, decoded results out. No dependencies.
`default_nettype none

interface ctd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface ctd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_end;

    modport source (output valid, output out_byte, output is_end, input ready);
    modport sink   (input valid, input out_byte, input is_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/ctd_cfg.sv =====
// APB-style configuration register block of the chunked transfer decoder.
// Depends on ctd_pkg.
`default_nettype none

module ctd_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic             o_chunked_enable
);

    logic r_chunked_enable;
    logic n_chunked_enable;
    logic w_sel_enable;

    assign w_sel_enable = (paddr[2:2] == ctd_pkg::REG_CHUNKED_ENABLE);
    assign pready       = 1'b1;

    always_comb begin
        n_chunked_enable = r_chunked_enable;
        if (psel && penable && pwrite && w_sel_enable) begin
            n_chunked_enable = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunked_enable <= 1'b0;
        end else begin
            r_chunked_enable <= n_chunked_enable;
        end
    end

    assign prdata           = w_sel_enable ? {31'd0, r_chunked_enable} : 32'd0;
    assign o_chunked_enable = r_chunked_enable;

endmodule

`default_nettype wire

// ===== rtl/ctd_core.sv =====
// Decoder state and per-byte update: size line parsing, chunk byte count
// and phase tracking. Depends on ctd_pkg.
`default_nettype none

module ctd_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic       [7:0] i_byte,
    input  wire logic             i_chunked_enable,
    output ctd_pkg::t_result      o_result
);

    logic [1:0]                  r_phase,  n_phase;
    logic [ctd_pkg::MAG_W-1:0]   r_acc,    n_acc;
    logic [2:0]                  r_stage,  n_stage;
    logic                        r_neg,    n_neg;
    logic [ctd_pkg::LEN_W-1:0]   r_len,    n_len;
    logic                        r_cr,     n_cr;
    logic [ctd_pkg::MAG_W-1:0]   r_rem,    n_rem;

    logic [4:0]                  w_hex;
    logic                        w_is_hex;
    logic [ctd_pkg::MAG_W-1:0]   w_acc_next;
    logic [ctd_pkg::MAG_W-1:0]   w_rem_dec;

    assign w_hex    = ctd_pkg::hex_digit(i_byte);
    assign w_is_hex = w_hex[4];

    // Shift in one hex digit, saturating at the largest 63-bit magnitude
    assign w_acc_next = (r_acc[ctd_pkg::MAG_W-1 -: 4] != 4'd0) ? ctd_pkg::SIZE_MAX
                      : {r_acc[ctd_pkg::MAG_W-5:0], w_hex[3:0]};

    assign w_rem_dec = (r_rem != '0) ? r_rem - ctd_pkg::MAG_W'(1) : r_rem;

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_stage  = r_stage;
        n_neg    = r_neg;
        n_len    = r_len;
        n_cr     = r_cr;
        n_rem    = r_rem;
        o_result = '{valid: 1'b0, data: i_byte, is_end: 1'b0};

        if (i_fire) begin
            if (!i_chunked_enable || r_phase == ctd_pkg::PH_PASS) begin
                o_result.valid = 1'b1;
            end else begin
                case (r_phase)
                    ctd_pkg::PH_DATA: begin
                        o_result.valid = 1'b1;
                        n_rem          = w_rem_dec;
                        if (w_rem_dec == '0) begin
                            n_phase = ctd_pkg::PH_LINE;
                            n_acc   = '0;
                            n_stage = ctd_pkg::ST_WS;
                            n_neg   = 1'b0;
                            n_len   = '0;
                            n_cr    = 1'b0;
                        end
                    end
                    ctd_pkg::PH_LINE: begin
                        if (i_byte != ctd_pkg::CH_LF) begin
                            if (r_len < ctd_pkg::LEN_W'(ctd_pkg::LINE_KEEP)) begin
                                n_len = r_len + ctd_pkg::LEN_W'(1);
                                n_cr  = (i_byte == ctd_pkg::CH_CR);
                                case (r_stage)
                                    ctd_pkg::ST_WS: begin
                                        if (ctd_pkg::is_space(i_byte)) begin
                                            n_stage = r_stage;
                                        end else if (i_byte == ctd_pkg::CH_PLUS ||
                                                     i_byte == ctd_pkg::CH_MINUS) begin
                                            n_neg   = (i_byte == ctd_pkg::CH_MINUS);
                                            n_stage = ctd_pkg::ST_SIGN;
                                        end else if (i_byte == ctd_pkg::CH_ZERO) begin
                                            n_stage = ctd_pkg::ST_ZERO;
                                        end else if (w_is_hex) begin
                                            n_acc   = w_acc_next;
                                            n_stage = ctd_pkg::ST_DIGITS;
                                        end else begin
                                            n_stage = ctd_pkg::ST_DEAD;
                                        end
                                    end
                                    ctd_pkg::ST_SIGN: begin
                                        if (i_byte == ctd_pkg::CH_ZERO) begin
                                            n_stage = ctd_pkg::ST_ZERO;
                                        end else if (w_is_hex) begin
                                            n_acc   = w_acc_next;
                                            n_stage = ctd_pkg::ST_DIGITS;
                                        end else begin
                                            n_stage = ctd_pkg::ST_DEAD;
                                        end
                                    end
                                    ctd_pkg::ST_ZERO: begin
                                        if (i_byte == ctd_pkg::CH_X_LO ||
                                            i_byte == ctd_pkg::CH_X_UP) begin
                                            n_stage = ctd_pkg::ST_X;
                                        end else if (w_is_hex) begin
                                            n_acc   = w_acc_next;
                                            n_stage = ctd_pkg::ST_DIGITS;
                                        end else begin
                                            n_stage = ctd_pkg::ST_DEAD;
                                        end
                                    end
                                    ctd_pkg::ST_X,
                                    ctd_pkg::ST_DIGITS: begin
                                        if (w_is_hex) begin
                                            n_acc   = w_acc_next;
                                            n_stage = ctd_pkg::ST_DIGITS;
                                        end else begin
                                            n_stage = ctd_pkg::ST_DEAD;
                                        end
                                    end
                                    default: begin
                                        n_stage = r_stage;
                                    end
                                endcase
                            end
                        end else begin
                            // End of line: clear the line state in every case
                            n_acc   = '0;
                            n_stage = ctd_pkg::ST_WS;
                            n_neg   = 1'b0;
                            n_len   = '0;
                            n_cr    = 1'b0;
                            if (!(r_len == '0 ||
                                  (r_len == ctd_pkg::LEN_W'(1) && r_cr))) begin
                                if (r_acc == '0) begin
                                    n_phase         = ctd_pkg::PH_DONE;
                                    o_result.valid  = 1'b1;
                                    o_result.data   = 8'd0;
                                    o_result.is_end = 1'b1;
                                end else if (r_neg) begin
                                    n_phase = ctd_pkg::PH_PASS;
                                end else begin
                                    n_rem   = r_acc;
                                    n_phase = ctd_pkg::PH_DATA;
                                end
                            end
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ctd_pkg::PH_LINE;
            r_acc   <= '0;
            r_stage <= ctd_pkg::ST_WS;
            r_neg   <= 1'b0;
            r_len   <= '0;
            r_cr    <= 1'b0;
            r_rem   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_stage <= n_stage;
            r_neg   <= n_neg;
            r_len   <= n_len;
            r_cr    <= n_cr;
            r_rem   <= n_rem;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/chunked_transfer_decoder.sv =====
// Top level of the chunked transfer decoder: input register, decode core,
// result register and configuration port. Depends on ctd_pkg, ctd_if.sv,
// ctd_cfg and ctd_core.
//
// Usage:
//   i_in carries raw response body bytes, one per transaction (valid/ready).
//   o_out carries decoded results: a payload byte with is_end low, or a single
//   end-of-body marker with is_end high and out_byte zero. A byte that is part
//   of a size line or trailing CRLF, or arrives after the end, yields nothing.
//   chunked_enable at address 0 of the APB port selects chunked decoding;
//   with it low every byte passes straight through. Write it only while idle.
//   Path: an accepted byte waits in the input register, and its result is loaded
//   into the result register, which drives o_out.valid.
//   Throughput: one byte per cycle while o_out is not held; the input register, the
//   combinational core update (shift-in of a hex digit or a 63-bit decrement) and
//   the result register form a two-stage pipeline with no bubbles.
//   Stall: while o_out is held, the result register keeps its transaction, the
//   input register takes at most one more byte, then i_in.ready drops.
//   Reset (synchronous, active low): both pipeline stages empty, decoder back
//   to the size line phase, chunked decoding off.
`default_nettype none

module chunked_transfer_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ctd_in_if.sink           i_in,
    ctd_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_end;
    logic             w_fire;
    logic             w_chunked_enable;
    ctd_pkg::t_result w_result;

    // Advance the input stage when the result register is free or draining
    assign w_fire     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_fire;

    ctd_cfg u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_chunked_enable (w_chunked_enable)
    );

    ctd_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (w_fire),
        .i_byte           (r_in_byte),
        .i_chunked_enable (w_chunked_enable),
        .o_result         (w_result)
    );

    // Input register: capture on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    // Result register: load when the core produces a result, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_result.valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_result.valid) begin
            r_out_byte <= w_result.data;
            r_out_end  <= w_result.is_end;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.is_end   = r_out_end;

endmodule

`default_nettype wire

// ===== test/chunked_transfer_decoder_test.sv =====
// Self-checking testbench for chunked_transfer_decoder: streams body bytes through the
// valid/ready channels, predicts every decoded result and compares it on the way out.
// Depends on ctd_pkg, the channel interfaces in ctd_if.sv and the decoder RTL.

module chunked_transfer_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ctd_pkg::*;

    // Longest run of cycles with no transaction on either channel before giving up.
    localparam int STALL_LIMIT = 2000;
    // Settle time after the pipeline drains, before touching the register.
    localparam int SETTLE_CYCLES = 4;
    // Bulk of the chunked body stream, in bytes.
    localparam int BODY_BYTES = 1700;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } decoded_t;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    ctd_in_if  in_if ();
    ctd_out_if out_if ();

    chunked_transfer_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Bytes built by the stimulus, bytes waiting for the driver, results still owed.
    logic [7:0] stream_q[$];
    logic [7:0] feed_q[$];
    decoded_t   decoded_q[$];

    int error_count = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    bit calm        = 1'b0;   // no idling on either side while set

    // Shadow of the decoder: register copy plus size line and chunk state.
    logic        chunked_on;
    logic [1:0]  dec_phase;
    logic [62:0] size_acc;
    logic [2:0]  parse_stage;
    logic        size_neg;
    logic [5:0]  line_len;
    logic        line_cr;
    logic [62:0] chunk_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_error(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ---------------------------------------------------------------------------------
    // Decoder model
    // ---------------------------------------------------------------------------------

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= CH_CR);
    endfunction

    // Hex digit value, -1 for anything that is not a hex digit.
    function automatic int hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic void clear_line();
        size_acc    = '0;
        parse_stage = ST_WS;
        size_neg    = 1'b0;
        line_len    = '0;
        line_cr     = 1'b0;
    endfunction

    // Shift in one hex digit, saturating at the largest 63-bit magnitude.
    function automatic void accumulate(input int d);
        logic [66:0] wide;
        if (size_acc > (SIZE_MAX >> 4)) begin
            size_acc = SIZE_MAX;
        end else begin
            wide = {size_acc, 4'(d)};
            size_acc = (wide > {4'b0, SIZE_MAX}) ? SIZE_MAX : wide[62:0];
        end
        parse_stage = ST_DIGITS;
    endfunction

    // One character of the size line, parsed like a base-16 strtoll.
    function automatic void parse_size_char(input logic [7:0] c);
        int d;
        d = hex_val(c);
        case (parse_stage)
            ST_WS: begin
                if (!is_blank(c)) begin
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        size_neg    = (c == CH_MINUS);
                        parse_stage = ST_SIGN;
                    end else if (c == CH_ZERO) begin
                        parse_stage = ST_ZERO;
                    end else if (d >= 0) begin
                        accumulate(d);
                    end else begin
                        parse_stage = ST_DEAD;
                    end
                end
            end
            ST_SIGN: begin
                if (c == CH_ZERO) parse_stage = ST_ZERO;
                else if (d >= 0) accumulate(d);
                else parse_stage = ST_DEAD;
            end
            ST_ZERO: begin
                if (c == CH_X_LO || c == CH_X_UP) parse_stage = ST_X;
                else if (d >= 0) accumulate(d);
                else parse_stage = ST_DEAD;
            end
            ST_X, ST_DIGITS: begin
                if (d >= 0) accumulate(d);
                else parse_stage = ST_DEAD;
            end
            default: ;  // stopped, and the unused codes behave the same
        endcase
    endfunction

    // Advance the model by one accepted byte and queue the result it owes, if any.
    function automatic void decode_byte(input logic [7:0] c);
        logic [62:0] mag;
        logic        neg;
        if (!chunked_on || dec_phase == PH_PASS) begin
            decoded_q.push_back('{data: c, last: 1'b0});
        end else if (dec_phase == PH_DATA) begin
            decoded_q.push_back('{data: c, last: 1'b0});
            if (chunk_left != 0) chunk_left--;
            if (chunk_left == 0) begin
                dec_phase = PH_LINE;
                clear_line();
            end
        end else if (dec_phase == PH_LINE) begin
            if (c != CH_LF) begin
                // Characters past the kept length are neither counted nor parsed.
                if (line_len < LINE_KEEP) begin
                    line_len++;
                    line_cr = (c == CH_CR);
                    parse_size_char(c);
                end
            end else if (line_len == 0 || (line_len == 1 && line_cr)) begin
                clear_line();
            end else begin
                mag = size_acc;
                neg = size_neg;
                clear_line();
                if (mag == 0) begin
                    dec_phase = PH_DONE;
                    decoded_q.push_back('{data: 8'h00, last: 1'b1});
                end else if (neg) begin
                    dec_phase = PH_PASS;
                end else begin
                    chunk_left = mag;
                    dec_phase  = PH_DATA;
                end
            end
        end
        // After the end of body nothing comes out.
    endfunction

    // ---------------------------------------------------------------------------------
    // Input driver: one transaction per accepted byte, random gaps between them
    // ---------------------------------------------------------------------------------

    always @(posedge i_clk) begin : feed_driver
        bit free;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                // Predict at acceptance so the expectation is queued before any result.
                decode_byte(in_if.in_byte);
                void'(feed_q.pop_front());
            end
            // Hold a stalled transaction; only open a gap when nothing is on the bus.
            free = !in_if.valid || in_if.ready;
            if (free && gap_left == 0 && !calm && feed_q.size() != 0
                    && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(1, 8);
            end
            if (free) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (feed_q.size() != 0) begin
                    in_if.valid   <= 1'b1;
                    in_if.in_byte <= feed_q[0];
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Output monitor: check each result transaction, stall ready in random bursts
    // ---------------------------------------------------------------------------------

    always @(posedge i_clk) begin : result_monitor
        decoded_t want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (decoded_q.size() == 0) begin
                    flag_error($sformatf("unexpected result byte=%02h end=%0b",
                                         out_if.out_byte, out_if.is_end));
                end else begin
                    want = decoded_q.pop_front();
                    if (out_if.out_byte !== want.data)
                        flag_error($sformatf("out_byte %02h, want %02h",
                                             out_if.out_byte, want.data));
                    if (out_if.is_end !== want.last)
                        flag_error($sformatf("is_end %0b, want %0b",
                                             out_if.is_end, want.last));
                end
            end
            if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 8);
            if (stall_left != 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Watchdog: give up after a long stretch with no transaction anywhere
    // ---------------------------------------------------------------------------------

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("chunked_transfer_decoder_test: errors");
        $finish;
    end

    // ---------------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------------

    // Setup then access phase; the register takes the value at the access edge.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_chunked(input logic on);
        write_reg({REG_CHUNKED_ENABLE, 2'b00}, {31'b0, on});
        chunked_on = on;
    endtask

    // Drain: nothing waiting, nothing on the bus, no result owed, pipeline flushed.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (feed_q.size() != 0 || in_if.valid || decoded_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic put(input logic [7:0] b);
        stream_q.push_back(b);
    endtask

    // Text followed by an optional CR and always an LF.
    task automatic put_line(input string s, input bit with_cr);
        foreach (s[i]) put(s[i]);
        if (with_cr) put(CH_CR);
        put(CH_LF);
    endtask

    function automatic logic [7:0] hex_char(input int unsigned d, input bit upper);
        if (d < 10) return 8'(int'(CH_ZERO) + d);
        return 8'((upper ? int'("A") : int'("a")) + d - 10);
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 4))
            0:       return 8'h09;
            1:       return 8'h0B;
            2:       return 8'h0C;
            3:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    // First character after the digits: never a hex digit, never LF.
    function automatic logic [7:0] stop_char();
        case ($urandom_range(0, 7))
            0:       return ";";
            1:       return CH_SPACE;
            2:       return 8'h09;
            3:       return "g";
            4:       return "z";
            5:       return 8'h00;
            6:       return 8'h7F;
            default: return 8'hFF;
        endcase
    endfunction

    // A well-formed size line for a nonzero size, in one of its many legal spellings.
    task automatic add_size_line(input int unsigned size);
        logic [7:0]  digits[$];
        logic [7:0]  b;
        int unsigned v;
        v = size;
        do begin
            digits.push_front(hex_char(v % 16, $urandom_range(0, 1)));
            v = v / 16;
        end while (v != 0);
        if ($urandom_range(0, 19) == 0) begin
            // Pad so the last real digit is the last kept character; the tail is dropped.
            repeat (LINE_KEEP - digits.size()) put(blank_char());
            foreach (digits[i]) put(digits[i]);
            repeat ($urandom_range(1, 4)) put(hex_char($urandom_range(0, 15), 1'b0));
        end else begin
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put(blank_char());
            if ($urandom_range(0, 5) == 0) put(CH_PLUS);
            if ($urandom_range(0, 3) == 0) begin
                put(CH_ZERO);
                put($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
            end
            if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) put(CH_ZERO);
            foreach (digits[i]) put(digits[i]);
            // Chunk extension or junk, sometimes long enough to overrun the kept length.
            if ($urandom_range(0, 3) == 0) begin
                put(stop_char());
                repeat ($urandom_range(0, 40)) begin
                    b = 8'($urandom_range(0, 255));
                    put(b == CH_LF ? CH_CR : b);
                end
            end
        end
        if ($urandom_range(0, 2) != 0) put(CH_CR);
        put(CH_LF);
    endtask

    task automatic add_chunk(input int unsigned size);
        add_size_line(size);
        repeat (size) put(8'($urandom_range(0, 255)));
        // Trailing line break, plain LF, none, or an extra empty line.
        case ($urandom_range(0, 5))
            0: ;
            1: put(CH_LF);
            2: begin put(CH_CR); put(CH_LF); put(CH_CR); put(CH_LF); end
            default: begin put(CH_CR); put(CH_LF); end
        endcase
    endtask

    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(0, 39);
        if (r == 0) return $urandom_range(200, 300);
        if (r < 6)  return $urandom_range(17, 80);
        return $urandom_range(1, 16);
    endfunction

    // Hand the next n built bytes to the driver and wait for every result.
    task automatic send_stream(input int unsigned n);
        @(negedge i_clk);
        repeat (n) if (stream_q.size() != 0) feed_q.push_back(stream_q.pop_front());
        wait_idle();
    endtask

    task automatic send_noise(input int unsigned n);
        @(negedge i_clk);
        repeat (n) feed_q.push_back(8'($urandom_range(0, 255)));
        wait_idle();
    endtask

    // ---------------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------------

    initial begin : stimulus
        in_if.valid   = 1'b0;
        in_if.in_byte = 8'h00;
        out_if.ready  = 1'b0;
        chunked_on    = 1'b0;
        dec_phase     = PH_LINE;
        chunk_left    = '0;
        clear_line();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Decoding off: every byte passes, LF and CR included, and the line state stays.
        set_chunked(1'b0);
        put(8'h00);
        put(8'hFF);
        put(CH_LF);
        put(CH_CR);
        send_stream(stream_q.size());

        // Decoding on: lone CR line, empty line, NUL stopping the parse, 0X prefix.
        set_chunked(1'b1);
        put(CH_CR);
        put(CH_LF);
        put(CH_LF);
        put("2");
        put(8'h00);
        put(CH_CR);
        put(CH_LF);
        put(8'h00);
        put(8'hFF);
        put(CH_CR);
        put(CH_LF);
        put_line(" 0X1", 1'b0);
        put(8'hA5);
        send_stream(stream_q.size());

        // Random well-formed body in segments; now and then drop to pass-through noise.
        while (stream_q.size() < BODY_BYTES) add_chunk(pick_size());
        while (stream_q.size() != 0) begin
            calm = ($urandom_range(0, 3) == 0);
            send_stream($urandom_range(100, 300));
            if ($urandom_range(0, 2) == 0) begin
                set_chunked(1'b0);
                send_noise($urandom_range(20, 60));
                set_chunked(1'b1);
            end
        end

        // One terminating size line; every form of it leaves the size line phase for good.
        calm = 1'b0;
        case ($urandom_range(0, 8))
            0: put_line("0", 1'b1);
            1: begin put(CH_CR); put_line("", 1'b1); end    // only blanks, parses as zero
            2: put_line("x", 1'b0);                          // no digits
            3: put_line("+", 1'b1);
            4: put_line("0x", 1'b1);
            5: put_line(" -0", 1'b1);                        // negative zero is still zero
            6: put_line("-1a", 1'b1);                        // negative: pass everything
            7: put_line("-fffffffffffffffffffff", 1'b0);     // saturated negative
            default: put_line("7FFFFFFFFFFFFFFFFFFFFFFF", 1'b1);  // saturated chunk size
        endcase
        repeat (40) put(8'($urandom_range(0, 255)));
        send_stream(stream_q.size());

        set_chunked(1'b0);
        send_noise($urandom_range(20, 40));
        set_chunked(1'b1);

        // Last stretch at full rate on both sides.
        calm = 1'b1;
        send_noise(40);

        repeat (8) @(negedge i_clk);
        if (error_count == 0)
            $display("chunked_transfer_decoder_test: clean");
        else
            $display("chunked_transfer_decoder_test: errors");
        $finish;
    end

endmodule

// ===== chunked_transfer_decoder.f =====
rtl/ctd_pkg.sv
rtl/ctd_if.sv
rtl/ctd_cfg.sv
rtl/ctd_core.sv
rtl/chunked_transfer_decoder.sv
test/chunked_transfer_decoder_test.sv
